>>> src/shcm_pkg.sv
package shcm_pkg;

  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 256;
  localparam int WINDOW   = 15;
  localparam int HALF_WIN = WINDOW / 2;
  localparam int BINS     = 32;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;

  localparam int POS_W  = 8;
  localparam int ADDR_W = 16;
  localparam int DIM_W  = 9;
  localparam int BIN_W  = 5;
  localparam int OFF_W  = 4;
  localparam int HIST_W = 8;
  localparam int CORR_W = 16;
  localparam int SUM_W  = CORR_W + BIN_W;
  localparam int CNT_W  = 8;
  localparam int PIX_W  = 8;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_COMPUTE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [1:0] REG_ROWS    = 2'd0;
  localparam logic [1:0] REG_COLS    = 2'd1;
  localparam logic [1:0] REG_REF_ROW = 2'd2;
  localparam logic [1:0] REG_REF_COL = 2'd3;

  // floor(v*32/255) as (x + 1 + (x >> 8)) >> 8 with x = v*32
  function automatic logic [BIN_W-1:0] pix_bin(input logic [PIX_W-1:0] v);
    logic [13:0] x;
    logic [13:0] y;
    x = {1'b0, v, 5'b0};
    y = x + 14'd1 + (x >> 8);
    return y[12:8];
  endfunction

  // Q0.16 of 10^(-4*d*d/225)
  function automatic logic [CORR_W-1:0] exp_lut(input logic [HIST_W-1:0] d);
    logic [CORR_W-1:0] e;
    case (d)
      8'd0:    e = 16'd65535;
      8'd1:    e = 16'd62907;
      8'd2:    e = 16'd55638;
      8'd3:    e = 16'd45340;
      8'd4:    e = 16'd34044;
      8'd5:    e = 16'd23552;
      8'd6:    e = 16'd15013;
      8'd7:    e = 16'd8818;
      8'd8:    e = 16'd4772;
      8'd9:    e = 16'd2379;
      8'd10:   e = 16'd1093;
      8'd11:   e = 16'd463;
      8'd12:   e = 16'd181;
      8'd13:   e = 16'd65;
      8'd14:   e = 16'd21;
      8'd15:   e = 16'd7;
      8'd16:   e = 16'd2;
      default: e = 16'd0;
    endcase
    return e;
  endfunction

endpackage

>>> src/speckle_histogram_correlation_map_core.sv
// Speckle correlation map core.
// Input beats: in_tuser carries the opcode (load, compute, read), in_tdata the
// row, column and pixel. A load writes one pixel and gives no output beat; loads
// are taken one per cycle. A read is registered as pending while the memories
// are read, then gives one output beat. A compute gives one output beat (the
// frame maximum) when it finishes. Compute runs: a pass clearing the correlation
// and count memories, the reference histogram, then per full window the pixel
// reads and a bin compare (one bin per cycle), then per interior pixel a check
// against the threshold and, if it is under, a neighbour scan. The pixel and
// correlation memory read ports, one access a cycle, set this pace.
// Only one command is in flight: in_tready is low while a compute runs, while a
// read is pending and while an output beat waits. A stalled receiver holds the
// output beat and the next input beat waits behind it.
// Reset: registers take their defaults and a clearing pass over every address zeros
// the correlation and count memories; no input beat is taken during that pass.
// Config writes land at once and must come only while the core is idle.
module speckle_histogram_correlation_map_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [23:0]                    in_tdata,   // row, col, pixel
  input  logic [1:0]                     in_tuser,   // opcode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [39:0]                    out_tdata,  // corr_value, factor_count, max_corr
  output logic [0:0]                     out_tuser,  // factor_valid
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_addr,
  input  logic [shcm_pkg::DIM_W-1:0]     cfg_wdata
);
  import shcm_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_REF  = 4'd2;
  localparam logic [3:0] S_REFW = 4'd3;
  localparam logic [3:0] S_HIST = 4'd4;
  localparam logic [3:0] S_HWT  = 4'd5;
  localparam logic [3:0] S_CMP  = 4'd6;
  localparam logic [3:0] S_CTR  = 4'd7;
  localparam logic [3:0] S_CTRW = 4'd8;
  localparam logic [3:0] S_NB   = 4'd9;
  localparam logic [3:0] S_NBW  = 4'd10;
  localparam logic [3:0] S_CWR  = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(WINDOW - 1);
  localparam logic [POS_W-1:0] HALF     = POS_W'(HALF_WIN);
  localparam logic [POS_W-1:0] FIRST_IN = POS_W'(HALF_WIN + 1);
  localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(BINS - 1);

  logic [DIM_W-1:0]  rows_r, cols_r;
  logic [POS_W-1:0]  ref_row_r, ref_col_r;
  logic [3:0]        st_r;
  logic [POS_W-1:0]  i_r, j_r;
  logic [OFF_W-1:0]  ro_r, co_r;
  logic [BIN_W-1:0]  k_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [ADDR_W-1:0] clr_r;
  logic              clr_init_r;
  logic [CORR_W-1:0] max_r;
  logic              hv_r, hv_ref_r, nv_r, rd_pend_r;
  logic [HIST_W-1:0] refh_r [BINS];
  logic [HIST_W-1:0] winh_r [BINS];
  logic              out_tvalid_r;
  logic [CORR_W-1:0] o_corr_r, o_max_r;
  logic [CNT_W-1:0]  o_cnt_r;
  logic              o_valid_r;

  logic [DIM_W-1:0]  rows_eff, cols_eff, top_tmp, left_tmp;
  logic [POS_W-1:0]  last_top, last_left, rr, rc;
  logic [POS_W-1:0]  in_row, in_col;
  logic [PIX_W-1:0]  in_pix;
  logic              accept, off_last;
  logic [POS_W-1:0]  win_row, win_col, nb_row, nb_col;
  logic [PIX_W-1:0]  pix_rdata;
  logic [CORR_W-1:0] corr_rdata;
  logic [CNT_W:0]    cnt_rdata;
  logic              pix_we, corr_we, cnt_we;
  logic [ADDR_W-1:0] corr_waddr, corr_raddr, cnt_waddr;
  logic [CORR_W-1:0] corr_wdata;
  logic [CNT_W:0]    cnt_wdata;
  logic [HIST_W-1:0] ha, hb, hd;
  logic [SUM_W-1:0]  sum_all;
  logic [CORR_W-1:0] corr_new;
  logic [BIN_W-1:0]  pbin;

  function automatic logic under(input logic [CORR_W-1:0] c, input logic [CORR_W-1:0] m);
    return {c, 2'b00} < ({2'b00, m} + {1'b0, m, 1'b0});
  endfunction

  assign in_row = in_tdata[7:0];
  assign in_col = in_tdata[15:8];
  assign in_pix = in_tdata[23:16];

  always_comb begin
    if (rows_r < 9'd16) rows_eff = 9'd16;
    else if (rows_r > DIM_W'(MAX_ROWS)) rows_eff = DIM_W'(MAX_ROWS);
    else rows_eff = rows_r;
    if (cols_r < 9'd16) cols_eff = 9'd16;
    else if (cols_r > DIM_W'(MAX_COLS)) cols_eff = DIM_W'(MAX_COLS);
    else cols_eff = cols_r;
  end

  assign top_tmp   = rows_eff - DIM_W'(WINDOW);
  assign left_tmp  = cols_eff - DIM_W'(WINDOW);
  assign last_top  = top_tmp[POS_W-1:0];
  assign last_left = left_tmp[POS_W-1:0];
  assign rr = (ref_row_r > last_top) ? last_top : ref_row_r;
  assign rc = (ref_col_r > last_left) ? last_left : ref_col_r;

  assign in_tready = (st_r == S_IDLE) && !rd_pend_r && !out_tvalid_r;
  assign accept    = in_tvalid && in_tready;
  assign off_last  = (ro_r == OFF_LAST) && (co_r == OFF_LAST);

  assign win_row = i_r + {4'b0, ro_r};
  assign win_col = j_r + {4'b0, co_r};
  assign nb_row  = i_r - HALF + {4'b0, ro_r};
  assign nb_col  = j_r - HALF + {4'b0, co_r};

  assign ha      = refh_r[k_r];
  assign hb      = winh_r[k_r];
  assign hd      = (ha > hb) ? (ha - hb) : (hb - ha);
  assign sum_all = sum_r + {{BIN_W{1'b0}}, exp_lut(hd)};
  assign corr_new = sum_all[SUM_W-1:BIN_W];
  assign pbin    = pix_bin(pix_rdata);

  assign pix_we = accept && (in_tuser == OP_LOAD);

  assign corr_we    = (st_r == S_CLR) || ((st_r == S_CMP) && (k_r == BIN_LAST));
  assign corr_waddr = (st_r == S_CLR) ? clr_r : {i_r + HALF, j_r + HALF};
  assign corr_wdata = (st_r == S_CLR) ? '0 : corr_new;

  always_comb begin
    if (st_r == S_IDLE) corr_raddr = {in_row, in_col};
    else if (st_r == S_NB) corr_raddr = {nb_row, nb_col};
    else corr_raddr = {i_r, j_r};
  end

  assign cnt_we    = (st_r == S_CLR) || (st_r == S_CWR);
  assign cnt_waddr = (st_r == S_CLR) ? clr_r : {i_r, j_r};
  assign cnt_wdata = (st_r == S_CLR) ? '0 : {1'b1, cnt_r};

  shcm_ram #(.WIDTH(PIX_W), .DEPTH(CELLS)) u_pix_ram (
    .clk(clk), .we(pix_we), .waddr({in_row, in_col}), .wdata(in_pix),
    .raddr({win_row, win_col}), .rdata(pix_rdata)
  );

  shcm_ram #(.WIDTH(CORR_W), .DEPTH(CELLS)) u_corr_ram (
    .clk(clk), .we(corr_we), .waddr(corr_waddr), .wdata(corr_wdata),
    .raddr(corr_raddr), .rdata(corr_rdata)
  );

  shcm_ram #(.WIDTH(CNT_W + 1), .DEPTH(CELLS)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr({in_row, in_col}), .rdata(cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r       <= DIM_W'(MAX_ROWS);
      cols_r       <= DIM_W'(MAX_COLS);
      ref_row_r    <= 8'd80;
      ref_col_r    <= 8'd215;
      st_r         <= S_CLR;
      clr_r        <= '0;
      clr_init_r   <= 1'b1;
      max_r        <= '0;
      hv_r         <= 1'b0;
      hv_ref_r     <= 1'b0;
      nv_r         <= 1'b0;
      rd_pend_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
      for (int b = 0; b < BINS; b++) begin
        refh_r[b] <= '0;
        winh_r[b] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_ROWS:    rows_r    <= cfg_wdata;
          REG_COLS:    cols_r    <= cfg_wdata;
          REG_REF_ROW: ref_row_r <= cfg_wdata[POS_W-1:0];
          REG_REF_COL: ref_col_r <= cfg_wdata[POS_W-1:0];
          default: ;
        endcase
      end

      if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;

      rd_pend_r <= accept && (in_tuser == OP_READ);
      if (rd_pend_r) begin
        out_tvalid_r <= 1'b1;
        o_corr_r     <= corr_rdata;
        o_cnt_r      <= cnt_rdata[CNT_W-1:0];
        o_valid_r    <= cnt_rdata[CNT_W];
        o_max_r      <= max_r;
      end

      hv_r <= 1'b0;
      nv_r <= 1'b0;

      // pixel beat back from the memory: bin it unless it is 0xFF
      if (hv_r && (pix_rdata != 8'hFF)) begin
        if (hv_ref_r) refh_r[pbin] <= refh_r[pbin] + 8'd1;
        else winh_r[pbin] <= winh_r[pbin] + 8'd1;
      end
      if (nv_r && under(corr_rdata, max_r)) cnt_r <= cnt_r + 8'd1;

      if ((st_r == S_REF) || (st_r == S_HIST) || (st_r == S_NB)) begin
        if (co_r == OFF_LAST) begin
          co_r <= '0;
          ro_r <= (ro_r == OFF_LAST) ? '0 : ro_r + 4'd1;
        end else begin
          co_r <= co_r + 4'd1;
        end
      end

      unique case (st_r)
        S_IDLE: begin
          if (accept && (in_tuser == OP_COMPUTE)) begin
            st_r       <= S_CLR;
            clr_r      <= '0;
            clr_init_r <= 1'b0;
            max_r      <= '0;
          end
        end
        S_CLR: begin
          clr_r <= clr_r + 16'd1;
          if (clr_r == {ADDR_W{1'b1}}) begin
            if (clr_init_r) begin
              st_r <= S_IDLE;
            end else begin
              st_r <= S_REF;
              i_r  <= rr;
              j_r  <= rc;
              ro_r <= '0;
              co_r <= '0;
              for (int b = 0; b < BINS; b++) begin
                refh_r[b] <= '0;
                winh_r[b] <= '0;
              end
            end
          end
        end
        S_REF: begin
          hv_r     <= 1'b1;
          hv_ref_r <= 1'b1;
          if (off_last) st_r <= S_REFW;
        end
        S_REFW: begin
          i_r  <= '0;
          j_r  <= '0;
          st_r <= S_HIST;
        end
        S_HIST: begin
          hv_r     <= 1'b1;
          hv_ref_r <= 1'b0;
          if (off_last) st_r <= S_HWT;
        end
        S_HWT: begin
          k_r   <= '0;
          sum_r <= '0;
          st_r  <= S_CMP;
        end
        S_CMP: begin
          sum_r <= sum_all;
          k_r   <= k_r + 5'd1;
          if (k_r == BIN_LAST) begin
            if (corr_new > max_r) max_r <= corr_new;
            for (int b = 0; b < BINS; b++) winh_r[b] <= '0;
            if (j_r == last_left) begin
              if (i_r == last_top) begin
                i_r  <= FIRST_IN;
                j_r  <= FIRST_IN;
                st_r <= S_CTR;
              end else begin
                i_r  <= i_r + 8'd1;
                j_r  <= '0;
                st_r <= S_HIST;
              end
            end else begin
              j_r  <= j_r + 8'd1;
              st_r <= S_HIST;
            end
          end
        end
        S_CTR: st_r <= S_CTRW;
        S_CTRW: begin
          if (under(corr_rdata, max_r)) begin
            ro_r  <= '0;
            co_r  <= '0;
            cnt_r <= '0;
            st_r  <= S_NB;
          end else if (j_r == last_left + HALF) begin
            j_r <= FIRST_IN;
            if (i_r == last_top + HALF) begin
              st_r <= S_DONE;
            end else begin
              i_r  <= i_r + 8'd1;
              st_r <= S_CTR;
            end
          end else begin
            j_r  <= j_r + 8'd1;
            st_r <= S_CTR;
          end
        end
        S_NB: begin
          nv_r <= 1'b1;
          if (off_last) st_r <= S_NBW;
        end
        S_NBW: st_r <= S_CWR;
        S_CWR: begin
          if (j_r == last_left + HALF) begin
            j_r <= FIRST_IN;
            if (i_r == last_top + HALF) begin
              st_r <= S_DONE;
            end else begin
              i_r  <= i_r + 8'd1;
              st_r <= S_CTR;
            end
          end else begin
            j_r  <= j_r + 8'd1;
            st_r <= S_CTR;
          end
        end
        S_DONE: begin
          out_tvalid_r <= 1'b1;
          o_corr_r     <= '0;
          o_cnt_r      <= '0;
          o_valid_r    <= 1'b0;
          o_max_r      <= max_r;
          st_r         <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {o_max_r, o_cnt_r, o_corr_r};
  assign out_tuser  = o_valid_r;

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid_r) else $error("input taken while output beat waits");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |=> out_tvalid_r) else $error("read gave no output beat");

  a_max_track: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == S_CMP) && (k_r == BIN_LAST)) |=> (max_r >= $past(corr_new)))
    else $error("maximum below a stored correlation");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CWR) |-> ((cnt_r != 8'd0) && (cnt_r <= 8'd225)))
    else $error("neighbor count out of range");

endmodule

>>> src/shcm_ram.sv
module shcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
